@@ sv/jmx_pkg.sv @@
// ----------------------------------------------------------------------------
// jmx_pkg
// Shared types and constants of the multiply-by-(x+1) spectral operator.
// ----------------------------------------------------------------------------
package jmx_pkg;

    // sample, weight and product widths
    localparam int SAMPLE_W = 32;
    localparam int WEIGHT_W = 18;
    localparam int PROD_W   = 51;

    // configuration port
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] ROW_LENGTH_RST     = 7'd17;
    localparam logic [CFG_W-1:0] ROWS_PER_PLANE_RST = 7'd1;
    localparam logic [CFG_W-1:0] PLANE_COUNT_RST    = 7'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_LENGTH     = 2'd0,
        REG_ROWS_PER_PLANE = 2'd1,
        REG_PLANE_COUNT    = 2'd2
    } cfg_reg_e;

    // result queue geometry
    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = 3;
    localparam int OQ_CW    = 4;

    // weights read for the two possible results of one sample
    typedef struct packed {
        logic [WEIGHT_W-1:0] lo_a;
        logic [WEIGHT_W-1:0] di_a;
        logic [WEIGHT_W-1:0] up_a;
        logic [WEIGHT_W-1:0] lo_b;
        logic [WEIGHT_W-1:0] di_b;
    } weights_t;

    // one finished result handed to the queue
    typedef struct packed {
        logic                vld;
        logic                last;
        logic [SAMPLE_W-1:0] product;
    } res_t;

endpackage

@@ sv/jmx_weight_rom.sv @@
// ----------------------------------------------------------------------------
// jmx_weight_rom
// Lower, diagonal and upper stencil weights in unsigned Q2.16, built at
// elaboration, read at two addresses with registered read data.
// ----------------------------------------------------------------------------
module jmx_weight_rom
    import jmx_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [$clog2(DEPTH)-1:0] addr_a,
    input  logic [$clog2(DEPTH)-1:0] addr_b,
    output weights_t                 rd
);

    logic [WEIGHT_W-1:0] lo_tab [DEPTH];
    logic [WEIGHT_W-1:0] di_tab [DEPTH];
    logic [WEIGHT_W-1:0] up_tab [DEPTH];

    // rounded ratios per radial index
    for (genvar gi = 0; gi < DEPTH; gi++)
    begin : g_rom
        localparam longint unsigned I      = gi;
        localparam longint unsigned LO_NUM = I * (I + 2);
        localparam longint unsigned LO_DEN = (I + 1) * (2 * I + 1);
        localparam longint unsigned DI_NUM = I * I + 3 * I + 3;
        localparam longint unsigned DI_DEN = (I + 1) * (I + 2);
        localparam longint unsigned UP_NUM = (I + 1) * (I + 3);
        localparam longint unsigned UP_DEN = (I + 2) * (2 * I + 5);
        localparam longint unsigned LO_Q   = (LO_NUM * 131072 + LO_DEN) / (2 * LO_DEN);
        localparam longint unsigned DI_Q   = (DI_NUM * 131072 + DI_DEN) / (2 * DI_DEN);
        localparam longint unsigned UP_Q   = (UP_NUM * 131072 + UP_DEN) / (2 * UP_DEN);

        assign lo_tab[gi] = LO_Q[WEIGHT_W-1:0];
        assign di_tab[gi] = DI_Q[WEIGHT_W-1:0];
        assign up_tab[gi] = UP_Q[WEIGHT_W-1:0];
    end

    // registered read, both ports
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd.lo_a <= lo_tab[addr_a];
            rd.di_a <= di_tab[addr_a];
            rd.up_a <= up_tab[addr_a];
            rd.lo_b <= lo_tab[addr_b];
            rd.di_b <= di_tab[addr_b];
        end
    end

endmodule

@@ sv/jmx_out_fifo.sv @@
// ----------------------------------------------------------------------------
// jmx_out_fifo
// Result queue: takes up to two results per cycle in order, gives one beat
// per cycle on the master stream side while m_tready is high.
// ----------------------------------------------------------------------------
module jmx_out_fifo
    import jmx_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  res_t                res_a,
    input  res_t                res_b,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata,
    output logic                m_tlast
);

    logic [SAMPLE_W:0] mem [OQ_DEPTH];

    logic [OQ_AW-1:0] wr_ptr_reg;
    logic [OQ_AW-1:0] wr_ptr_next;
    logic [OQ_AW-1:0] rd_ptr_reg;
    logic [OQ_AW-1:0] rd_ptr_next;
    logic [OQ_CW-1:0] count_reg;
    logic [OQ_CW-1:0] count_next;
    logic [1:0]       push_n;
    logic             pop;
    res_t             first_res;

    // first written entry is a when present, else b
    always_comb
    begin
        push_n    = {1'b0, res_a.vld} + {1'b0, res_b.vld};
        first_res = res_a.vld ? res_a : res_b;
        pop       = m_tvalid && m_tready;
    end

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OQ_AW'(push_n);
        rd_ptr_next = rd_ptr_reg + OQ_AW'(pop);
        count_next  = count_reg + OQ_CW'(push_n) - OQ_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage writes
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= {first_res.last, first_res.product};
        end
        if (push_n == 2'd2)
        begin
            mem[wr_ptr_reg + OQ_AW'(1)] <= {res_b.last, res_b.product};
        end
    end

    // head of queue
    always_comb
    begin
        m_tvalid = (count_reg != '0);
        m_tdata  = mem[rd_ptr_reg][SAMPLE_W-1:0];
        m_tlast  = mem[rd_ptr_reg][SAMPLE_W];
    end

endmodule

@@ sv/jacobi02_multiply_x_plus_one_core.sv @@
// ----------------------------------------------------------------------------
// jacobi02_multiply_x_plus_one_core
// Three-tap multiply-by-(x+1) operator on a Jacobi(0,2) coefficient stream.
// ----------------------------------------------------------------------------
// The block takes one Q16.16 sample per clock while s_tready is high and
// applies per-index lower, diagonal and upper Q2.16 weights to the current
// sample and the two before it in a row. Each sample after the first of a
// row releases one result, the last sample of a row releases two, so a row
// of nr samples gives nr results. A sample passes operand capture and weight
// ROM read on the accepting edge, then products, then round and saturate,
// then the queue write, after which it is offered on the master side. The
// two results at a row end are written together and drained one beat per
// cycle while m_tready is high; the queue of eight entries drops s_tready
// while seven or more results are outstanding, so with the master side
// always ready the sustained rate is one sample per cycle.
// Planes at index 1 or at or beyond the phi bound give zero with normal
// timing. cfg_ready is always high.
// ----------------------------------------------------------------------------
module jacobi02_multiply_x_plus_one_core
    import jmx_pkg::*;
#(
    parameter int MAX_ROW_LENGTH = 64,
    parameter int MAX_ROWS       = 64,
    parameter int MAX_PLANES     = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [SAMPLE_W-1:0]  s_tdata,   // [31:0] sample
    input  logic                 s_tuser,   // [0] table_start
    // output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [SAMPLE_W-1:0]  m_tdata,   // [31:0] product
    output logic                 m_tlast    // table_end
);

    // index and count widths
    localparam int RIW = $clog2(MAX_ROW_LENGTH);
    localparam int NRW = $clog2(MAX_ROW_LENGTH + 1);
    localparam int TIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int TCW = $clog2(MAX_ROWS + 1);
    localparam int PIW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int PCW = ($clog2(MAX_PLANES + 1) < 2) ? 2 : $clog2(MAX_PLANES + 1);

    localparam logic signed [36:0] SAT_HI = 37'sd2147483647;
    localparam logic signed [36:0] SAT_LO = -37'sd2147483648;

    // configuration registers
    logic [CFG_W-1:0] row_length_reg;
    logic [CFG_W-1:0] rows_per_plane_reg;
    logic [CFG_W-1:0] plane_count_reg;

    // stream state
    logic [RIW-1:0]      r_reg,  r_next;
    logic [TIW-1:0]      t_reg,  t_next;
    logic [PIW-1:0]      p_reg,  p_next;
    logic [SAMPLE_W-1:0] prev_reg;
    logic [SAMPLE_W-1:0] older_reg;
    logic [OQ_CW-1:0]    used_reg, used_next;

    // stage 1: operands
    logic                s1_valid_reg;
    logic                s1_first_reg;
    logic                s1_second_reg;
    logic                s1_zero_reg;
    logic                s1_last_reg;
    logic [SAMPLE_W-1:0] s1_x_reg;
    logic [SAMPLE_W-1:0] s1_prev_reg;
    logic [SAMPLE_W-1:0] s1_older_reg;
    weights_t            s1_w;

    // stage 2: products
    logic                     s2_valid_reg;
    logic                     s2_first_reg;
    logic                     s2_second_reg;
    logic                     s2_zero_reg;
    logic                     s2_last_reg;
    logic signed [PROD_W-1:0] pa0_reg, pa1_reg, pa2_reg;
    logic signed [PROD_W-1:0] pb0_reg, pb1_reg;

    // stage 3: finished results
    res_t res_a_reg;
    res_t res_b_reg;

    // decoded position of the incoming sample
    logic [NRW-1:0] nr_eff;
    logic [TCW-1:0] nt_eff;
    logic [PCW-1:0] npl_eff;
    logic [PCW-1:0] bound;
    logic [RIW-1:0] r_cur;
    logic [TIW-1:0] t_cur;
    logic [PIW-1:0] p_cur;
    logic           cur_first;
    logic           cur_second;
    logic           cur_zero;
    logic           cur_last;
    logic           accept;
    logic           pop;

    function automatic logic signed [PROD_W-1:0] mulw(logic [WEIGHT_W-1:0] w,
                                                      logic [SAMPLE_W-1:0] s);
        logic signed [PROD_W-1:0] we;
        logic signed [PROD_W-1:0] se;
        we = {{(PROD_W - WEIGHT_W){1'b0}}, w};
        se = {{(PROD_W - SAMPLE_W){s[SAMPLE_W-1]}}, s};
        return we * se;
    endfunction

    // round half up to Q16.16 and saturate
    function automatic logic [SAMPLE_W-1:0] rnd_sat(logic signed [PROD_W-1:0] a,
                                                    logic signed [PROD_W-1:0] b,
                                                    logic signed [PROD_W-1:0] c);
        logic signed [52:0] acc;
        logic signed [36:0] q;
        logic [SAMPLE_W-1:0] res;
        acc = {{2{a[PROD_W-1]}}, a} + {{2{b[PROD_W-1]}}, b} + {{2{c[PROD_W-1]}}, c}
              + 53'sd32768;
        q = acc[52:16];
        if (q > SAT_HI)
            res = 32'h7FFF_FFFF;
        else if (q < SAT_LO)
            res = 32'h8000_0000;
        else
            res = q[SAMPLE_W-1:0];
        return res;
    endfunction

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg     <= ROW_LENGTH_RST;
            rows_per_plane_reg <= ROWS_PER_PLANE_RST;
            plane_count_reg    <= PLANE_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROW_LENGTH:     row_length_reg     <= cfg_data;
                REG_ROWS_PER_PLANE: rows_per_plane_reg <= cfg_data;
                REG_PLANE_COUNT:    plane_count_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    // effective dimensions, clamped into range
    always_comb
    begin
        if (row_length_reg < 7'd2)
            nr_eff = NRW'(2);
        else if (32'(row_length_reg) > MAX_ROW_LENGTH)
            nr_eff = NRW'(MAX_ROW_LENGTH);
        else
            nr_eff = NRW'(row_length_reg);

        if (rows_per_plane_reg < 7'd1)
            nt_eff = TCW'(1);
        else if (32'(rows_per_plane_reg) > MAX_ROWS)
            nt_eff = TCW'(MAX_ROWS);
        else
            nt_eff = TCW'(rows_per_plane_reg);

        if (plane_count_reg < 7'd1)
            npl_eff = PCW'(1);
        else if (32'(plane_count_reg) > MAX_PLANES)
            npl_eff = PCW'(MAX_PLANES);
        else
            npl_eff = PCW'(plane_count_reg);

        bound = (npl_eff == PCW'(3)) ? PCW'(1) : npl_eff - PCW'(1);
    end

    // position of this sample and the next
    always_comb
    begin
        r_cur = s_tuser ? '0 : r_reg;
        t_cur = s_tuser ? '0 : t_reg;
        p_cur = s_tuser ? '0 : p_reg;
        if (NRW'(r_cur) >= nr_eff)
            r_cur = '0;
        if (TCW'(t_cur) >= nt_eff)
            t_cur = '0;
        if (PCW'(p_cur) >= npl_eff)
            p_cur = '0;

        cur_first  = (r_cur != '0);
        cur_second = (NRW'(r_cur) == nr_eff - NRW'(1));
        cur_zero   = (PCW'(p_cur) == PCW'(1)) || (PCW'(p_cur) >= bound);
        cur_last   = (TCW'(t_cur) == nt_eff - TCW'(1))
                     && (PCW'(p_cur) == npl_eff - PCW'(1));

        r_next = r_cur + RIW'(1);
        t_next = t_cur;
        p_next = p_cur;
        if (cur_second)
        begin
            r_next = '0;
            t_next = t_cur + TIW'(1);
            if (TCW'(t_cur) == nt_eff - TCW'(1))
            begin
                t_next = '0;
                p_next = p_cur + PIW'(1);
                if (PCW'(p_cur) == npl_eff - PCW'(1))
                    p_next = '0;
            end
        end
    end

    // credit for outstanding results
    always_comb
    begin
        s_tready  = (used_reg <= OQ_CW'(OQ_DEPTH - 2));
        accept    = s_tvalid && s_tready;
        pop       = m_tvalid && m_tready;
        used_next = used_reg - OQ_CW'(pop);
        if (accept)
            used_next = used_next + OQ_CW'(cur_first) + OQ_CW'(cur_second);
    end

    // control registers, stage 3 sum, round, saturate, zero-plane masking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg        <= '0;
            t_reg        <= '0;
            p_reg        <= '0;
            prev_reg     <= '0;
            older_reg    <= '0;
            used_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            res_a_reg    <= '0;
            res_b_reg    <= '0;
        end
        else
        begin
            used_reg      <= used_next;
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            res_a_reg.vld <= s2_valid_reg && s2_first_reg;
            res_b_reg.vld <= s2_valid_reg && s2_second_reg;
            res_a_reg.last    <= 1'b0;
            res_b_reg.last    <= s2_last_reg;
            res_a_reg.product <= s2_zero_reg ? '0 : rnd_sat(pa0_reg, pa1_reg, pa2_reg);
            res_b_reg.product <= s2_zero_reg ? '0 : rnd_sat(pb0_reg, pb1_reg, '0);
            if (accept)
            begin
                r_reg     <= r_next;
                t_reg     <= t_next;
                p_reg     <= p_next;
                older_reg <= prev_reg;
                prev_reg  <= s_tdata;
            end
        end
    end

    // weight lookup, registered alongside stage 1
    jmx_weight_rom #(
        .DEPTH (MAX_ROW_LENGTH)
    ) u_rom (
        .clk    (clk),
        .en     (accept),
        .addr_a (r_cur - RIW'(1)),
        .addr_b (r_cur),
        .rd     (s1_w)
    );

    // stage 1 operands
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_first_reg  <= cur_first;
            s1_second_reg <= cur_second;
            s1_zero_reg   <= cur_zero;
            s1_last_reg   <= cur_last;
            s1_x_reg      <= s_tdata;
            s1_prev_reg   <= prev_reg;
            s1_older_reg  <= older_reg;
        end
    end

    // stage 2 products
    always_ff @(posedge clk)
    begin
        s2_first_reg  <= s1_first_reg;
        s2_second_reg <= s1_second_reg;
        s2_zero_reg   <= s1_zero_reg;
        s2_last_reg   <= s1_last_reg;
        pa0_reg       <= mulw(s1_w.lo_a, s1_older_reg);
        pa1_reg       <= mulw(s1_w.di_a, s1_prev_reg);
        pa2_reg       <= mulw(s1_w.up_a, s1_x_reg);
        pb0_reg       <= mulw(s1_w.lo_b, s1_prev_reg);
        pb1_reg       <= mulw(s1_w.di_b, s1_x_reg);
    end

    // result queue
    jmx_out_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_a    (res_a_reg),
        .res_b    (res_b_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // credit never exceeds queue capacity
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= OQ_CW'(OQ_DEPTH))
        else $error("outstanding result count beyond queue depth");

    // a beat on the master side is always covered by credit
    a_valid_credit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (used_reg != '0))
        else $error("output valid with no outstanding result");

    // the row-end result never comes without the regular one
    a_second_first: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_second_reg) |-> s1_first_reg)
        else $error("row end sample without preceding tap result");

    // stalled input means the queue credit is used up
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (used_reg >= OQ_CW'(OQ_DEPTH - 1)))
        else $error("input stalled with credit left");

endmodule
